[design/bse_pkg.sv]
// shared codes, sizes and bit-scan helpers for the bitmap set engine
package bse_pkg;

  // operation codes carried in the func field
  localparam logic [2:0] FUNC_INCLUDE = 3'd0;
  localparam logic [2:0] FUNC_EXCLUDE = 3'd1;
  localparam logic [2:0] FUNC_TEST    = 3'd2;
  localparam logic [2:0] FUNC_FIND    = 3'd3;
  localparam logic [2:0] FUNC_COUNT   = 3'd4;
  localparam logic [2:0] FUNC_CLEAR   = 3'd5;

  // field widths
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;

  // widest chunk handled by the scan unit in one step
  localparam int unsigned CHUNK_MAX = 64;

  // swar population count of one chunk
  function automatic logic [6:0] popcnt64(input logic [63:0] x);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] s;
    a = x - ((x >> 1) & 64'h5555_5555_5555_5555);
    b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
    c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    s = c + (c >> 8);
    s = s + (s >> 16);
    s = s + (s >> 32);
    return s[6:0];
  endfunction

  // position of the lowest set bit, zero when none is set
  function automatic logic [5:0] lowbit64(input logic [63:0] x);
    logic [63:0] lsb;
    logic [5:0]  pos;
    lsb    = x & (~x + 64'd1);
    pos[0] = |(lsb & 64'hAAAA_AAAA_AAAA_AAAA);
    pos[1] = |(lsb & 64'hCCCC_CCCC_CCCC_CCCC);
    pos[2] = |(lsb & 64'hF0F0_F0F0_F0F0_F0F0);
    pos[3] = |(lsb & 64'hFF00_FF00_FF00_FF00);
    pos[4] = |(lsb & 64'hFFFF_0000_FFFF_0000);
    pos[5] = |(lsb & 64'hFFFF_FFFF_0000_0000);
    return pos;
  endfunction

endpackage

[design/bitmap_set_engine.sv]
// bitmap set engine top level: bit store, chunk scan unit and handshakes
//
// usage
//   requests enter on the s_axis channel, one transaction per operation:
//   include, exclude, test, find next set, count, clear all. every request
//   gives exactly one result transaction on the m_axis channel.
//   the highest usable bit index is written on the cfg channel (always
//   ready); the effective limit is the smaller of it and MAX_BITS-1, and
//   it must only be changed while the engine is idle.
// timing
//   include, exclude, test, clear and unused codes: the result is ready in
//   the cycle after the request transaction, a new request every cycle while
//   the output register is free.
//   find next and count: the map is walked by one shared 64-bit scan unit
//   (mask, popcount, lowest-set-bit), one chunk per cycle; count walks all
//   NCH chunks, find next stops early when a hit comes. with 256 bits NCH is 4.
// reset
//   the bitmap is cleared, the limit goes to 255, both channels go idle.
// back-pressure
//   a result waits in the output register while m_axis_tready is low; a
//   new request is still taken if the register drains in the same cycle,
//   and a finished scan holds its last step until the register is free.
module bitmap_set_engine #(
  parameter int unsigned MAX_BITS = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request: [2:0] func, [10:3] bit_index, upper bits zero
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bse_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // result: [0] status, [1] found, [9:2] position, [18:10] set_count
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bse_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // limit register write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bse_pkg::INDEX_W-1:0]     cfg_data_i
);
  import bse_pkg::*;

  // only indices up to 255 are reachable, so store no more than 256 bits
  localparam int unsigned NBITS = (MAX_BITS < 256) ? MAX_BITS : 256;
  localparam int unsigned CW    = (NBITS < CHUNK_MAX) ? NBITS : CHUNK_MAX;
  localparam int unsigned NCH   = (NBITS + CW - 1) / CW;
  localparam int unsigned PADW  = NCH * CW;
  localparam int unsigned IW    = (PADW > 1) ? $clog2(PADW) : 1;
  localparam int unsigned CIW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam logic [INDEX_W-1:0] TOP = INDEX_W'(NBITS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;

  logic [1:0]          state_q, state_d;
  logic [PADW-1:0]     store_q;
  logic [INDEX_W-1:0]  max_index_q;
  logic [CIW-1:0]      chunk_q;
  logic [INDEX_W-1:0]  lo_q;
  logic                is_find_q;
  logic [COUNT_W-1:0]  acc_q;

  logic                out_valid_q;
  logic                out_status_q;
  logic                out_found_q;
  logic [INDEX_W-1:0]  out_pos_q;
  logic [COUNT_W-1:0]  out_count_q;

  // request fields
  logic [FUNC_W-1:0]   req_func;
  logic [INDEX_W-1:0]  req_idx;
  logic [IW-1:0]       req_addr;
  logic                req_fire;
  logic                in_range;
  logic [INDEX_W-1:0]  lim;
  logic                out_free;

  // scan unit
  logic [INDEX_W-1:0]  base;
  logic [63:0]         chunk_raw;
  logic [63:0]         chunk_keep;
  logic [6:0]          chunk_pc;
  logic [5:0]          chunk_low;
  logic                hit;
  logic                last;
  logic                scan_done;

  assign req_func = s_axis_tdata[FUNC_W-1:0];
  assign req_idx  = s_axis_tdata[FUNC_W +: INDEX_W];
  assign req_addr = IW'(req_idx);
  assign lim      = (max_index_q > TOP) ? TOP : max_index_q;
  assign in_range = (req_idx <= lim);
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign req_fire      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // one chunk of the map, masked to [lo, lim]
  assign base      = INDEX_W'(chunk_q * CW);
  assign chunk_raw = 64'(store_q[chunk_q * CW +: CW]);

  always_comb begin
    for (int j = 0; j < CHUNK_MAX; j++) begin
      chunk_keep[j] = chunk_raw[j] && (j < CW) &&
                      ((base + INDEX_W'(j)) >= lo_q) &&
                      ((base + INDEX_W'(j)) <= lim);
    end
  end

  assign chunk_pc  = popcnt64(chunk_keep);
  assign chunk_low = lowbit64(chunk_keep);
  assign hit       = is_find_q && (chunk_keep != 64'd0);
  assign last      = (chunk_q == CIW'(NCH - 1));
  assign scan_done = (state_q == ST_SCAN) && (hit || last) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire && (req_func == FUNC_FIND || req_func == FUNC_COUNT)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state, map and limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      store_q     <= '0;
      max_index_q <= 8'hFF;
      out_valid_q <= 1'b0;
      chunk_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid && cfg_ready) begin
        max_index_q <= cfg_data_i;
      end
      if (req_fire) begin
        case (req_func)
          FUNC_INCLUDE: if (in_range) store_q[req_addr] <= 1'b1;
          FUNC_EXCLUDE: if (in_range) store_q[req_addr] <= 1'b0;
          FUNC_CLEAR:   store_q <= '0;
          default:      ;
        endcase
      end
      if (req_fire) begin
        chunk_q <= '0;
      end else if (state_q == ST_SCAN && !(hit || last)) begin
        chunk_q <= chunk_q + CIW'(1);
      end
      if (req_fire && !(req_func == FUNC_FIND || req_func == FUNC_COUNT)) begin
        out_valid_q <= 1'b1;
      end else if (scan_done) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // scan context and result payload
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      lo_q      <= (req_func == FUNC_FIND) ? req_idx : '0;
      is_find_q <= (req_func == FUNC_FIND);
      acc_q     <= '0;
      out_status_q <= (req_func == FUNC_INCLUDE) && !in_range;
      out_found_q  <= (req_func == FUNC_TEST) && in_range && store_q[req_addr];
      out_pos_q    <= '0;
      out_count_q  <= '0;
    end else if (state_q == ST_SCAN) begin
      if (!(hit || last)) begin
        acc_q <= acc_q + COUNT_W'(chunk_pc);
      end else if (out_free) begin
        out_status_q <= 1'b0;
        out_found_q  <= hit;
        out_pos_q    <= hit ? (base + INDEX_W'(chunk_low)) : '0;
        out_count_q  <= is_find_q ? '0 : (acc_q + COUNT_W'(chunk_pc));
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_count_q, out_pos_q, out_found_q, out_status_q};

  // no request taken while a scan is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !s_axis_tready)
    else $error("request accepted during scan");

  // a refused include never reports a hit or a count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |-> (!out_found_q && out_count_q == '0))
    else $error("refused include carries other results");

  // a nonzero count comes with no find result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_count_q != '0) |-> (!out_found_q && out_pos_q == '0))
    else $error("count result mixed with find result");

  // found position never lies above the effective limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && $past(state_q) == ST_SCAN && out_found_q) |-> (out_pos_q <= lim))
    else $error("find result above limit");

  // chunk counter stays inside the map
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (32'(chunk_q) <= NCH - 1))
    else $error("chunk counter out of range");

endmodule

[tb/bse_checker.sv]
// checker for the bitmap set engine: watches the three channels, predicts each result and compares
`timescale 1ns / 100ps
module bse_checker #(
  parameter int unsigned MAX_BITS = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [bse_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [2:0] func, [10:3] bit_index
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [bse_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [0] status, [1] found,
                                                          // [9:2] position, [18:10] set_count
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [bse_pkg::INDEX_W-1:0]     cfg_data_i,
  output int unsigned                     errors_o,
  output int unsigned                     pending_o,
  output int unsigned                     requests_o,
  output int unsigned                     results_o
);
  import bse_pkg::*;

  typedef struct packed {
    logic               status;
    logic               found;
    logic [INDEX_W-1:0] position;
    logic [COUNT_W-1:0] set_count;
  } bse_result_t;

  logic [MAX_BITS-1:0] set_map;
  logic [INDEX_W-1:0]  max_index;
  bse_result_t         expected_results[$];
  bse_result_t         want;
  int unsigned         err_cnt;
  int unsigned         req_cnt;
  int unsigned         rsp_cnt;

  // applies one request to the mirrored bitmap and returns the result it should give
  function automatic bse_result_t bitmap_result(input logic [FUNC_W-1:0]  fn,
                                                input logic [INDEX_W-1:0] idx);
    bse_result_t r;
    int unsigned lim;
    int unsigned k;
    r   = '0;
    lim = (32'(max_index) > MAX_BITS - 1) ? MAX_BITS - 1 : 32'(max_index);
    case (fn)
      FUNC_INCLUDE: begin
        if (idx > lim) r.status = 1'b1;
        else set_map[idx] = 1'b1;
      end
      FUNC_EXCLUDE: begin
        if (idx <= lim) set_map[idx] = 1'b0;
      end
      FUNC_TEST: begin
        if (idx <= lim) r.found = set_map[idx];
      end
      FUNC_FIND: begin
        for (k = 32'(idx); k <= lim; k++) begin
          if (set_map[k]) begin
            r.found    = 1'b1;
            r.position = k[INDEX_W-1:0];
            break;
          end
        end
      end
      FUNC_COUNT: begin
        for (k = 0; k <= lim; k++) r.set_count = r.set_count + COUNT_W'(set_map[k]);
      end
      FUNC_CLEAR: begin
        set_map = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      err_cnt++;
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_map   = '0;
      max_index = 8'hFF;
      expected_results.delete();
      err_cnt   = 0;
      req_cnt   = 0;
      rsp_cnt   = 0;
      errors_o   <= 0;
      pending_o  <= 0;
      requests_o <= 0;
      results_o  <= 0;
    end else begin
      // results first: the front entry is always older than a request taken at this edge
      if (m_axis_tvalid && m_axis_tready) begin
        rsp_cnt++;
        if (expected_results.size() == 0) begin
          err_cnt++;
          $error("result 0x%h with no request outstanding", m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(m_axis_tdata[0]));
          check_field("found", 32'(want.found), 32'(m_axis_tdata[1]));
          check_field("position", 32'(want.position), 32'(m_axis_tdata[9:2]));
          check_field("set_count", 32'(want.set_count), 32'(m_axis_tdata[18:10]));
        end
      end
      if (cfg_valid && cfg_ready) max_index = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        req_cnt++;
        expected_results.push_back(bitmap_result(s_axis_tdata[2:0], s_axis_tdata[10:3]));
      end
      errors_o   <= err_cnt;
      pending_o  <= expected_results.size();
      requests_o <= req_cnt;
      results_o  <= rsp_cnt;
    end
  end

endmodule

[tb/tb_top.sv]
// testbench top for the bitmap set engine: clock, reset, request and limit stimulus, verdict
`timescale 1ns / 100ps
module tb_top;
  import bse_pkg::*;

  // func codes the engine treats as no operation
  localparam logic [FUNC_W-1:0] FUNC_SPARE6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE7 = 3'd7;

  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS  = 240;
  localparam int unsigned BURST_ITEMS  = 80;    // gapless requests during the long hold-off
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned SETTLE_CYC   = 8;     // longer than a full count scan
  localparam longint      CYCLE_LIMIT  = 1000000;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [2:0] func, [10:3] bit_index
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [0] status, [1] found, [9:2] position,
                                                // [18:10] set_count
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic [INDEX_W-1:0]     cfg_data_i    = '0;

  int unsigned        errors;
  int unsigned        pending;
  int unsigned        requests;
  int unsigned        results;
  int unsigned        limit_writes  = 0;
  logic [INDEX_W-1:0] cur_limit     = 8'hFF;
  longint             cycles        = 0;

  // flags shared between the request driver and the result sink
  bit hold_off_req = 1'b0;
  bit src_steady   = 1'b0;
  bit sink_steady  = 1'b0;

  bitmap_set_engine #(
    .MAX_BITS(256)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data_i   (cfg_data_i)
  );

  bse_checker #(
    .MAX_BITS(256)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data_i   (cfg_data_i),
    .errors_o     (errors),
    .pending_o    (pending),
    .requests_o   (requests),
    .results_o    (results)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // gap length: mostly short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return FUNC_INCLUDE;
    if (r < 50) return FUNC_EXCLUDE;
    if (r < 67) return FUNC_TEST;
    if (r < 85) return FUNC_FIND;
    if (r < 94) return FUNC_COUNT;
    if (r < 96) return FUNC_CLEAR;
    return (r < 98) ? FUNC_SPARE6 : FUNC_SPARE7;
  endfunction

  // indices mostly inside the limit, with the limit edges and the full range mixed in
  function automatic logic [INDEX_W-1:0] pick_index(input logic [INDEX_W-1:0] lim);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return INDEX_W'($urandom_range(0, 32'(lim)));
    if (r < 75) return lim;
    if (r < 80) return (lim == 8'hFF) ? 8'hFF : lim + 8'd1;
    return INDEX_W'($urandom_range(0, 255));
  endfunction

  // result sink: random stalls, a steady stretch on request, one long hold-off
  initial begin : result_sink
    int unsigned n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk_i);
    end
  end

  // one request transaction, then maybe an idle gap; otherwise valid stays high into the next request
  task automatic send_req(input logic [FUNC_W-1:0] fn, input logic [INDEX_W-1:0] idx);
    s_axis_tdata  <= {{(IN_TDATA_W - FUNC_W - INDEX_W){1'b0}}, idx, fn};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (!src_steady && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle_len()) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every result is back, then let the engine settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // only called from an idle engine, right after drain
  task automatic write_limit(input logic [INDEX_W-1:0] v);
    cfg_data_i <= v;
    cfg_valid  <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    cur_limit = v;
    limit_writes++;
  endtask

  task automatic run_directed();
    write_limit(8'hFF);
    // empty map
    send_req(FUNC_TEST, 8'd0);
    send_req(FUNC_FIND, 8'd0);
    send_req(FUNC_COUNT, 8'd0);
    // both ends and a couple inside
    send_req(FUNC_INCLUDE, 8'd0);
    send_req(FUNC_INCLUDE, 8'd255);
    send_req(FUNC_INCLUDE, 8'd200);
    send_req(FUNC_INCLUDE, 8'd50);
    send_req(FUNC_FIND, 8'd1);
    send_req(FUNC_FIND, 8'd201);
    send_req(FUNC_FIND, 8'd255);
    send_req(FUNC_TEST, 8'd255);
    send_req(FUNC_COUNT, 8'hFF);
    send_req(FUNC_EXCLUDE, 8'd255);
    send_req(FUNC_FIND, 8'd201);
    send_req(FUNC_SPARE6, 8'hAA);
    send_req(FUNC_SPARE7, 8'h55);
    // lowered limit: bit 200 becomes hidden
    drain();
    write_limit(8'd100);
    send_req(FUNC_INCLUDE, 8'd200);
    send_req(FUNC_EXCLUDE, 8'd200);
    send_req(FUNC_TEST, 8'd200);
    send_req(FUNC_FIND, 8'd51);
    send_req(FUNC_FIND, 8'd150);
    send_req(FUNC_COUNT, 8'd0);
    send_req(FUNC_INCLUDE, 8'd100);
    send_req(FUNC_FIND, 8'd51);
    // raised again: the hidden bit is back
    drain();
    write_limit(8'hFF);
    send_req(FUNC_TEST, 8'd200);
    // clear while hidden, then look again
    drain();
    write_limit(8'd100);
    send_req(FUNC_CLEAR, 8'd0);
    drain();
    write_limit(8'hFF);
    send_req(FUNC_TEST, 8'd200);
    send_req(FUNC_COUNT, 8'd0);
  endtask

  initial begin : stimulus
    logic [INDEX_W-1:0] phase_limit [NUM_PHASES];
    int unsigned ph;
    int unsigned i;
    // extremes, a small map, the pressure phase at mid range, and random settings
    phase_limit[0] = 8'd0;
    phase_limit[1] = 8'd7;
    phase_limit[2] = INDEX_W'($urandom_range(8, 254));
    phase_limit[3] = 8'd1;
    phase_limit[4] = 8'd128;
    phase_limit[5] = INDEX_W'($urandom_range(0, 255));
    phase_limit[6] = INDEX_W'($urandom_range(16, 64));
    phase_limit[7] = 8'hFF;
    wait (rst_ni);
    @(posedge clk_i);
    run_directed();
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      write_limit(phase_limit[ph]);
      // one phase with no idling on either side
      src_steady  = (ph == 5);
      sink_steady = (ph == 5);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // pressure: the sink holds off while requests keep coming back to back
        if (ph == 4 && i == 0) begin
          src_steady   = 1'b1;
          hold_off_req = 1'b1;
        end
        if (ph == 4 && i == BURST_ITEMS) src_steady = 1'b0;
        send_req(pick_func(), pick_index(cur_limit));
      end
    end
    drain();
    $display("run covered %0d requests and %0d results over %0d limit writes",
             requests, results, limit_writes);
    $display("all six operations, both unused codes, limits 0 to 255, one long sink stall");
    if (errors == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
